@@ rtl/core/qhd_pkg.sv @@
package qhd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 12;

  localparam int MODE_W    = 2;
  localparam int POS_W     = 3;
  localparam int SYMBOL_W  = 6;
  localparam int COUNT_W   = 3;
  localparam int NUM_CELLS = 7;

  localparam logic [MODE_W-1:0] MODE_QPSK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QAM16 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QAM64 = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos_i;
    logic [POS_W-1:0] pos_q;
  } qhd_tag_t;

  function automatic longint scaled_level(longint mag, longint pw, int frac);
    longint target;
    longint lo;
    longint hi;
    longint mid;
    longint t;
    target = 4 * mag * mag * (longint'(1) << (2 * frac));
    lo = 0;
    hi = longint'(1) << (frac + 3);
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      t = 2 * mid - 1;
      if (t * t * pw < target) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo;
  endfunction

  function automatic longint axis_level(int k, int p, int frac);
    longint num_levels;
    longint a;
    longint pw;
    longint m;
    num_levels = longint'(1) << k;
    a = 2 * longint'(p) - num_levels + 1;
    pw = (k == 1) ? 2 : ((k == 2) ? 10 : 42);
    m = scaled_level((a < 0) ? -a : a, pw, frac);
    return (a < 0) ? -m : m;
  endfunction

  function automatic int gray(int p);
    return p ^ (p >> 1);
  endfunction

  function automatic logic [POS_W-1:0] gray_bits(logic [POS_W-1:0] p);
    return p ^ (p >> 1);
  endfunction

endpackage

@@ rtl/core/qhd_if.sv @@
interface qhd_sample_if #(
  parameter int SAMPLE_WIDTH = qhd_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] in_phase;
  logic signed [SAMPLE_WIDTH-1:0] quadrature;

  modport source (output valid, output in_phase, output quadrature, input ready);
  modport sink (input valid, input in_phase, input quadrature, output ready);
endinterface

interface qhd_result_if;
  logic                          valid;
  logic                          ready;
  logic [qhd_pkg::SYMBOL_W-1:0]  symbol_bits;
  logic [qhd_pkg::COUNT_W-1:0]   bit_count;

  modport source (output valid, output symbol_bits, output bit_count, input ready);
  modport sink (input valid, input symbol_bits, input bit_count, output ready);
endinterface

interface qhd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [qhd_pkg::MODE_W-1:0]  modulation_mode;

  modport source (output valid, output modulation_mode, input ready);
  modport sink (input valid, input modulation_mode, output ready);
endinterface

@@ rtl/core/qhd_cell.sv @@
module qhd_cell #(
  parameter int SAMPLE_WIDTH = qhd_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = qhd_pkg::FRAC_BITS_DEF,
  parameter int CELL_IDX     = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [qhd_pkg::MODE_W-1:0]     mode,
  input  qhd_pkg::qhd_tag_t              in_tag,
  input  logic signed [SAMPLE_WIDTH-1:0] in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_q,
  output qhd_pkg::qhd_tag_t              out_tag,
  output logic signed [SAMPLE_WIDTH-1:0] out_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_q
);

  localparam int CW = (SAMPLE_WIDTH + 1 > FRAC_BITS + 3) ? SAMPLE_WIDTH + 1 : FRAC_BITS + 3;

  // Each cell holds the decision boundary between axis positions CELL_IDX and CELL_IDX + 1.
  localparam logic signed [CW-1:0] SUM_1 = CW'(qhd_pkg::axis_level(1, CELL_IDX, FRAC_BITS)
                                            + qhd_pkg::axis_level(1, CELL_IDX + 1, FRAC_BITS));
  localparam logic signed [CW-1:0] SUM_2 = CW'(qhd_pkg::axis_level(2, CELL_IDX, FRAC_BITS)
                                            + qhd_pkg::axis_level(2, CELL_IDX + 1, FRAC_BITS));
  localparam logic signed [CW-1:0] SUM_3 = CW'(qhd_pkg::axis_level(3, CELL_IDX, FRAC_BITS)
                                            + qhd_pkg::axis_level(3, CELL_IDX + 1, FRAC_BITS));
  localparam bit TIE_UP   = qhd_pkg::gray(CELL_IDX + 1) < qhd_pkg::gray(CELL_IDX);
  localparam bit ACTIVE_1 = CELL_IDX < 1;
  localparam bit ACTIVE_2 = CELL_IDX < 3;
  localparam bit ACTIVE_3 = CELL_IDX < 7;

  logic signed [CW-1:0] sum;
  logic                 active;
  logic signed [CW-1:0] twice_i;
  logic signed [CW-1:0] twice_q;
  logic                 step_i;
  logic                 step_q;

  always_comb begin
    case (mode)
      qhd_pkg::MODE_QPSK: begin
        sum    = SUM_1;
        active = ACTIVE_1;
      end
      qhd_pkg::MODE_QAM16: begin
        sum    = SUM_2;
        active = ACTIVE_2;
      end
      default: begin
        sum    = SUM_3;
        active = ACTIVE_3;
      end
    endcase
  end

  assign twice_i = CW'(in_i) <<< 1;
  assign twice_q = CW'(in_q) <<< 1;

  // A sample exactly on the boundary goes to the side with the lower bit group.
  assign step_i = active && (TIE_UP ? (twice_i >= sum) : (twice_i > sum));
  assign step_q = active && (TIE_UP ? (twice_q >= sum) : (twice_q > sum));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag.valid <= 1'b0;
    end else if (en) begin
      out_tag.valid <= in_tag.valid;
    end
    if (en) begin
      out_tag.pos_i <= in_tag.pos_i + qhd_pkg::POS_W'(step_i);
      out_tag.pos_q <= in_tag.pos_q + qhd_pkg::POS_W'(step_q);
      out_i         <= in_i;
      out_q         <= in_q;
    end
  end

endmodule

@@ rtl/core/qam_hard_demapper_unit.sv @@
// Channel  Direction  Payload
// cfg      in         modulation_mode (2 bits)
// sample   in         in_phase, quadrature (SAMPLE_WIDTH bits each, signed)
// result   out        symbol_bits (6 bits), bit_count (3 bits)
//
// A sample beat passes through each cell of the boundary chain in turn, and one beat
// can enter every cycle while the chain is not held. There is one result beat per sample beat.
// Reset clears the modulation mode to QPSK and empties the chain.
// While a result waits and result.ready is low the whole chain holds and sample.ready is low.
// The configuration channel is always ready.
module qam_hard_demapper_unit #(
  parameter int SAMPLE_WIDTH = qhd_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = qhd_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  qhd_cfg_if.sink            cfg,
  qhd_sample_if.sink         sample,
  qhd_result_if.source       result
);

  localparam int N = qhd_pkg::NUM_CELLS;

  logic [qhd_pkg::MODE_W-1:0]     mode;
  logic                           en;
  qhd_pkg::qhd_tag_t              tag [N+1];
  logic signed [SAMPLE_WIDTH-1:0] chain_i [N];
  logic signed [SAMPLE_WIDTH-1:0] chain_q [N];
  logic [qhd_pkg::POS_W-1:0]      g_i;
  logic [qhd_pkg::POS_W-1:0]      g_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= qhd_pkg::MODE_QPSK;
    end else if (cfg.valid) begin
      mode <= cfg.modulation_mode;
    end
  end

  assign en           = !tag[N].valid || result.ready;
  assign sample.ready = en;

  assign tag[0].valid = sample.valid;
  assign tag[0].pos_i = '0;
  assign tag[0].pos_q = '0;
  assign chain_i[0]   = sample.in_phase;
  assign chain_q[0]   = sample.quadrature;

  for (genvar j = 0; j < N; j++) begin : g_cell
    if (j < N - 1) begin : g_mid
      qhd_cell #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS),
        .CELL_IDX     (j)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .en      (en),
        .mode    (mode),
        .in_tag  (tag[j]),
        .in_i    (chain_i[j]),
        .in_q    (chain_q[j]),
        .out_tag (tag[j+1]),
        .out_i   (chain_i[j+1]),
        .out_q   (chain_q[j+1])
      );
    end else begin : g_last
      qhd_cell #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS),
        .CELL_IDX     (j)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .en      (en),
        .mode    (mode),
        .in_tag  (tag[j]),
        .in_i    (chain_i[j]),
        .in_q    (chain_q[j]),
        .out_tag (tag[j+1]),
        .out_i   (),
        .out_q   ()
      );
    end
  end

  assign g_i = qhd_pkg::gray_bits(tag[N].pos_i);
  assign g_q = qhd_pkg::gray_bits(tag[N].pos_q);

  assign result.valid = tag[N].valid;

  always_comb begin
    case (mode)
      qhd_pkg::MODE_QPSK: begin
        result.symbol_bits = {4'b0000, g_i[0], g_q[0]};
        result.bit_count   = 3'd2;
      end
      qhd_pkg::MODE_QAM16: begin
        result.symbol_bits = {2'b00, g_i[1:0], g_q[1:0]};
        result.bit_count   = 3'd4;
      end
      default: begin
        result.symbol_bits = {g_i, g_q};
        result.bit_count   = 3'd6;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_qpsk_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && mode == qhd_pkg::MODE_QPSK |->
      tag[N].pos_i <= 3'd1 && tag[N].pos_q <= 3'd1)
    else $error("QPSK decision beyond the second axis position");

  a_qam16_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && mode == qhd_pkg::MODE_QAM16 |->
      tag[N].pos_i <= 3'd3 && tag[N].pos_q <= 3'd3)
    else $error("16-QAM decision beyond the fourth axis position");

  a_chain_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(tag[N]) && $stable(tag[1]))
    else $error("Cell chain moved while the result was stalled");

  a_entry_to_cell: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> tag[1].valid)
    else $error("Accepted sample beat did not enter the first cell");
`endif

endmodule

@@ tb/qhd_symbol_checker.sv @@
`timescale 1ns / 100ps

module qhd_symbol_checker (
  input  logic  clk,
  input  logic  rst,
  qhd_cfg_if    cfg,
  qhd_sample_if sample,
  qhd_result_if result,
  output int    mismatch_count,
  output int    symbols_in_flight
);
  import qhd_pkg::*;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol_bits;
    logic [COUNT_W-1:0]  bit_count;
  } decision_t;

  logic [MODE_W-1:0] mode_shadow;
  decision_t         pending_decisions[$];

  // Odd PAM level at axis position pos, scaled to unit average power and rounded.
  function automatic longint point_level(int k, int pos);
    int     a;
    real    pw;
    longint m;
    a  = 2 * pos - (1 << k) + 1;
    pw = (k == 1) ? 2.0 : ((k == 2) ? 10.0 : 42.0);
    m  = longint'($floor(((a < 0) ? -a : a) * real'(1 << FRAC_BITS_DEF) / $sqrt(pw) + 0.5));
    return (a < 0) ? -m : m;
  endfunction

  function automatic decision_t demap_nearest(logic [MODE_W-1:0] mode,
                                              logic signed [SAMPLE_WIDTH_DEF-1:0] samp_i,
                                              logic signed [SAMPLE_WIDTH_DEF-1:0] samp_q);
    int        k;
    int        count;
    int        best_idx;
    longint    lev[8];
    longint    di;
    longint    sq_dist;
    longint    best;
    bit        first;
    decision_t r;
    k     = (mode == MODE_QPSK) ? 1 : ((mode == MODE_QAM16) ? 2 : 3);
    count = 1 << k;
    for (int g = 0; g < count; g++) begin
      for (int p = 0; p < count; p++) begin
        if ((p ^ (p >> 1)) == g) begin
          lev[g] = point_level(k, p);
        end
      end
    end
    first    = 1'b1;
    best     = 0;
    best_idx = 0;
    for (int gi = 0; gi < count; gi++) begin
      di = (longint'(samp_i) - lev[gi]) * (longint'(samp_i) - lev[gi]);
      for (int gq = 0; gq < count; gq++) begin
        sq_dist = di + (longint'(samp_q) - lev[gq]) * (longint'(samp_q) - lev[gq]);
        if (first || sq_dist < best) begin
          first    = 1'b0;
          best     = sq_dist;
          best_idx = (gi << k) | gq;
        end
      end
    end
    r.symbol_bits = SYMBOL_W'(best_idx);
    r.bit_count   = COUNT_W'(2 * k);
    return r;
  endfunction

  always @(posedge clk) begin
    decision_t want;
    if (rst) begin
      mode_shadow = MODE_QPSK;
      pending_decisions.delete();
      mismatch_count = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (pending_decisions.size() == 0) begin
          $display("%0t: result beat with none outstanding: expected none, got %0d/%0d",
                   $time, result.symbol_bits, result.bit_count);
          mismatch_count++;
        end else begin
          want = pending_decisions.pop_front();
          if (result.symbol_bits !== want.symbol_bits) begin
            $display("%0t: symbol_bits expected %0d, got %0d",
                     $time, want.symbol_bits, result.symbol_bits);
            mismatch_count++;
          end
          if (result.bit_count !== want.bit_count) begin
            $display("%0t: bit_count expected %0d, got %0d",
                     $time, want.bit_count, result.bit_count);
            mismatch_count++;
          end
        end
      end
      if (sample.valid && sample.ready) begin
        pending_decisions.push_back(demap_nearest(mode_shadow, sample.in_phase,
                                                  sample.quadrature));
      end
      if (cfg.valid && cfg.ready) begin
        mode_shadow = cfg.modulation_mode;
      end
    end
    symbols_in_flight = pending_decisions.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import qhd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SATURATED = 2'd3;
  localparam int IDLE_PERCENT = 35;
  localparam int PHASE_ITEMS  = 220;
  localparam int NUM_PHASES   = 8;
  localparam int FULL_RATE_PHASE = 5;
  localparam int NUM_DIRECTED = 8;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  bit                full_rate = 1'b0;
  logic [MODE_W-1:0] cur_mode = MODE_QPSK;
  int                mismatch_count;
  int                symbols_in_flight;

  logic [MODE_W-1:0] phase_modes[NUM_PHASES] = '{MODE_QPSK, MODE_QAM64, MODE_QAM16,
                                                 MODE_SATURATED, MODE_QPSK, MODE_QAM64,
                                                 MODE_QAM16, MODE_QAM64};
  int directed_i[NUM_DIRECTED] = '{-32768, 32767, -32768, 32767, 0, 0, 32767, -1};
  int directed_q[NUM_DIRECTED] = '{-32768, 32767, 32767, -32768, 0, -32768, 0, -1};

  qhd_cfg_if    cfg_ch ();
  qhd_sample_if sample_ch ();
  qhd_result_if result_ch ();

  qam_hard_demapper_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (sample_ch),
    .result (result_ch)
  );

  qhd_symbol_checker u_chk (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg_ch),
    .sample            (sample_ch),
    .result            (result_ch),
    .mismatch_count    (mismatch_count),
    .symbols_in_flight (symbols_in_flight)
  );

  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= full_rate || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Random axis value: anywhere in range, near a point, or close to a decision boundary.
  function automatic int pick_axis(logic [MODE_W-1:0] mode);
    int  k;
    int  count;
    int  sel;
    int  pos;
    int  spread;
    real unit;
    k      = (mode == MODE_QPSK) ? 1 : ((mode == MODE_QAM16) ? 2 : 3);
    count  = 1 << k;
    unit   = real'(1 << FRAC_BITS_DEF) / $sqrt((k == 1) ? 2.0 : ((k == 2) ? 10.0 : 42.0));
    spread = $rtoi(unit);
    sel    = $urandom_range(99);
    if (sel < 40) begin
      return int'($urandom_range(65535)) - 32768;
    end else if (sel < 75) begin
      pos = $urandom_range(count - 1);
      return $rtoi((2 * pos - count + 1) * unit) + int'($urandom_range(2 * spread)) - spread;
    end
    pos = $urandom_range(count - 2);
    return $rtoi((2 * pos - count + 2) * unit) + int'($urandom_range(6)) - 3;
  endfunction

  task automatic send_sample(input int val_i, input int val_q);
    while (!full_rate && $urandom_range(99) < IDLE_PERCENT) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.in_phase   <= SAMPLE_WIDTH_DEF'(val_i);
    sample_ch.quadrature <= SAMPLE_WIDTH_DEF'(val_q);
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    while (symbols_in_flight != 0) @(negedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] mode);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.modulation_mode <= mode;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cur_mode = mode;
  endtask

  initial begin
    cfg_ch.valid           = 1'b0;
    cfg_ch.modulation_mode = MODE_QPSK;
    sample_ch.valid        = 1'b0;
    sample_ch.in_phase     = '0;
    sample_ch.quadrature   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // The mode is only changed once every outstanding beat has come back.
      if (phase != 0) begin
        wait_drained();
        write_mode(phase_modes[phase]);
      end
      full_rate = (phase == FULL_RATE_PHASE);
      if (phase < 3) begin
        for (int n = 0; n < NUM_DIRECTED; n++) begin
          send_sample(directed_i[n], directed_q[n]);
        end
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == PHASE_ITEMS / 2) begin
          wait_drained();
        end
        send_sample(pick_axis(cur_mode), pick_axis(cur_mode));
      end
    end

    full_rate = 1'b0;
    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
